### rtl/core/sha256_pkg.sv
// Shared types, constants and round functions for the SHA-256 hash engine.
package sha256_pkg;

    // One word of a padded 512-bit block, as passed from front to back
    typedef struct packed {
        logic [31:0] word;
        logic        msg_end;   // last word of the final block of a message
    } blk_word_t;

    // Front sequencer states
    typedef enum logic [4:0] {
        F_IDLE   = 5'b00001,
        F_PAD    = 5'b00010,
        F_ZERO   = 5'b00100,
        F_LEN_HI = 5'b01000,
        F_LEN_LO = 5'b10000
    } front_state_t;

    // Back (compression) states
    typedef enum logic [3:0] {
        B_LOAD  = 4'b0001,
        B_ROUND = 4'b0010,
        B_UPD   = 4'b0100,
        B_OUT   = 4'b1000
    } back_state_t;

    localparam int unsigned BLOCK_WORDS = 16;
    localparam int unsigned ROUNDS      = 64;
    localparam int unsigned HASH_WORDS  = 8;

    localparam logic [3:0]  LEN_SLOT  = 4'd14;        // block slot of the length high word
    localparam logic [31:0] PAD_WORD  = 32'h8000_0000;
    localparam logic [2:0]  FULL_WORD = 3'd4;

    localparam logic [31:0] INIT_HASH [HASH_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned s);
        rotr = (x >> s) | (x << (32 - s));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] ch_fn(input logic [31:0] e, input logic [31:0] f,
                                          input logic [31:0] g);
        ch_fn = (e & f) ^ (~e & g);
    endfunction

    function automatic logic [31:0] maj_fn(input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] c);
        maj_fn = (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage

### rtl/core/sha256_front.sv
// Front end: accepts message words, counts bytes and emits padded block words.
module sha256_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_word,
    input  logic [2:0]            s_valid_bytes,
    input  logic                  s_last,
    output logic                  push_valid,
    input  logic                  push_ready,
    output sha256_pkg::blk_word_t push_data
);
    import sha256_pkg::*;

    front_state_t state_reg, state_next;
    logic [3:0]   cnt_reg, cnt_next;       // word slot within the current block
    logic [60:0]  bytes_reg, bytes_next;   // message length in bytes, wraps
    logic [2:0]   nvalid;
    logic [31:0]  tail_word;
    logic         push;
    logic [63:0]  bit_len;

    assign bit_len = {bytes_reg, 3'b000};
    assign push    = push_valid && push_ready;

    // valid byte count: only a last word may be short, and more than four means four
    always_comb begin
        if (!s_last || s_valid_bytes > FULL_WORD) begin
            nvalid = FULL_WORD;
        end else begin
            nvalid = s_valid_bytes;
        end
    end

    // short last word: clear the unused bytes and place the pad byte
    always_comb begin
        case (nvalid[1:0])
            2'd0:    tail_word = PAD_WORD;
            2'd1:    tail_word = {s_word[31:24], 24'h80_0000};
            2'd2:    tail_word = {s_word[31:16], 16'h8000};
            2'd3:    tail_word = {s_word[31:8], 8'h80};
            default: tail_word = PAD_WORD;
        endcase
    end

    // word generation and sequencing
    always_comb begin
        state_next         = state_reg;
        cnt_next           = cnt_reg;
        bytes_next         = bytes_reg;
        push_valid         = 1'b0;
        push_data.word     = s_word;
        push_data.msg_end  = 1'b0;
        s_tready           = 1'b0;
        case (state_reg)
            F_IDLE: begin
                s_tready   = push_ready;
                push_valid = s_tvalid;
                if (s_last && nvalid != FULL_WORD) begin
                    push_data.word = tail_word;
                end
                if (s_tvalid && push_ready) begin
                    cnt_next   = cnt_reg + 4'd1;
                    bytes_next = bytes_reg + 61'(nvalid);
                    if (s_last) begin
                        state_next = (nvalid == FULL_WORD) ? F_PAD : F_ZERO;
                    end
                end
            end
            F_PAD: begin
                push_valid     = 1'b1;
                push_data.word = PAD_WORD;
                if (push_ready) begin
                    cnt_next   = cnt_reg + 4'd1;
                    state_next = F_ZERO;
                end
            end
            F_ZERO: begin
                push_data.word = '0;
                if (cnt_reg == LEN_SLOT) begin
                    state_next = F_LEN_HI;
                end else begin
                    push_valid = 1'b1;
                    if (push_ready) begin
                        cnt_next = cnt_reg + 4'd1;
                    end
                end
            end
            F_LEN_HI: begin
                push_valid     = 1'b1;
                push_data.word = bit_len[63:32];
                if (push_ready) begin
                    cnt_next   = cnt_reg + 4'd1;
                    state_next = F_LEN_LO;
                end
            end
            F_LEN_LO: begin
                push_valid        = 1'b1;
                push_data.word    = bit_len[31:0];
                push_data.msg_end = 1'b1;
                if (push_ready) begin
                    cnt_next   = '0;
                    bytes_next = '0;
                    state_next = F_IDLE;
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
            bytes_reg <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            bytes_reg <= bytes_next;
        end
    end

`ifndef SYNTHESIS
    // the length low word always closes a block
    a_len_closes_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == F_LEN_LO && push) |-> cnt_reg == 4'd15)
        else $error("length word not in the last block slot");

    // a message end leaves the counters cleared for the next message
    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == F_LEN_LO && push) |=> (cnt_reg == '0 && bytes_reg == '0))
        else $error("counters not cleared after message end");
`endif

endmodule

### rtl/core/sha256_queue.sv
// Short queue of block words between the front end and the compression core.
module sha256_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  sha256_pkg::blk_word_t in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output sha256_pkg::blk_word_t out_data
);
    import sha256_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    blk_word_t       slot_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   fill_reg, fill_next;
    logic            wr_en;
    logic            rd_en;

    assign in_ready  = fill_reg != CW'(DEPTH);
    assign out_valid = fill_reg != '0;
    assign out_data  = slot_reg[rd_ptr_reg];
    assign wr_en     = in_valid && in_ready;
    assign rd_en     = out_valid && out_ready;

    // pointer and fill update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (wr_en) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (rd_en) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (wr_en && !rd_en) begin
            fill_next = fill_reg + CW'(1);
        end else if (rd_en && !wr_en) begin
            fill_next = fill_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

### rtl/core/sha256_back.sv
// Compression core: loads 16-word blocks, runs 64 rounds, updates and emits the digest.
module sha256_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  pop_valid,
    output logic                  pop_ready,
    input  sha256_pkg::blk_word_t pop_data,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_digest_word,
    output logic [2:0]            m_word_index,
    output logic                  m_last_word
);
    import sha256_pkg::*;

    back_state_t state_reg, state_next;
    logic [3:0]  load_cnt_reg, load_cnt_next;
    logic [5:0]  round_cnt_reg, round_cnt_next;
    logic [2:0]  out_idx_reg, out_idx_next;
    logic        end_reg, end_next;          // current block ends the message

    logic [31:0] hash_reg [HASH_WORDS];
    logic [31:0] w_reg [BLOCK_WORDS];        // message schedule window
    logic [31:0] v_reg [HASH_WORDS];         // working variables a..h

    logic        pop;
    logic        out_take;
    logic [31:0] w_new;
    logic [31:0] t1;
    logic [31:0] t2;

    assign pop       = pop_valid && pop_ready;
    assign pop_ready = state_reg == B_LOAD;
    assign out_take  = m_tvalid && m_tready;

    assign m_tvalid      = state_reg == B_OUT;
    assign m_digest_word = hash_reg[0];
    assign m_word_index  = out_idx_reg;
    assign m_last_word   = out_idx_reg == 3'(HASH_WORDS - 1);

    // schedule expansion and round function
    assign w_new = small_sigma1(w_reg[14]) + w_reg[9] + small_sigma0(w_reg[1]) + w_reg[0];
    assign t1    = v_reg[7] + big_sigma1(v_reg[4]) + ch_fn(v_reg[4], v_reg[5], v_reg[6])
                 + ROUND_K[round_cnt_reg] + w_reg[0];
    assign t2    = big_sigma0(v_reg[0]) + maj_fn(v_reg[0], v_reg[1], v_reg[2]);

    // sequencing
    always_comb begin
        state_next     = state_reg;
        load_cnt_next  = load_cnt_reg;
        round_cnt_next = round_cnt_reg;
        out_idx_next   = out_idx_reg;
        end_next       = end_reg;
        case (state_reg)
            B_LOAD: begin
                if (pop) begin
                    load_cnt_next = load_cnt_reg + 4'd1;
                    end_next      = pop_data.msg_end;
                    if (load_cnt_reg == 4'(BLOCK_WORDS - 1)) begin
                        round_cnt_next = '0;
                        state_next     = B_ROUND;
                    end
                end
            end
            B_ROUND: begin
                round_cnt_next = round_cnt_reg + 6'd1;
                if (round_cnt_reg == 6'(ROUNDS - 1)) begin
                    state_next = B_UPD;
                end
            end
            B_UPD: begin
                out_idx_next = '0;
                state_next   = end_reg ? B_OUT : B_LOAD;
            end
            B_OUT: begin
                if (out_take) begin
                    out_idx_next = out_idx_reg + 3'd1;
                    if (m_last_word) begin
                        state_next = B_LOAD;
                    end
                end
            end
            default: begin
                state_next = B_LOAD;
            end
        endcase
    end

    // control and hash state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_LOAD;
            load_cnt_reg  <= '0;
            round_cnt_reg <= '0;
            out_idx_reg   <= '0;
            end_reg       <= 1'b0;
            hash_reg      <= INIT_HASH;
        end else begin
            state_reg     <= state_next;
            load_cnt_reg  <= load_cnt_next;
            round_cnt_reg <= round_cnt_next;
            out_idx_reg   <= out_idx_next;
            end_reg       <= end_next;
            if (state_reg == B_UPD) begin
                for (int i = 0; i < HASH_WORDS; i++) begin
                    hash_reg[i] <= hash_reg[i] + v_reg[i];
                end
            end else if (state_reg == B_OUT && out_take) begin
                // shift the digest out; initial values refill from the top
                for (int i = 0; i < HASH_WORDS - 1; i++) begin
                    hash_reg[i] <= hash_reg[i + 1];
                end
                hash_reg[HASH_WORDS - 1] <= INIT_HASH[out_idx_reg];
            end
        end
    end

    // schedule window and working variables
    always_ff @(posedge aclk) begin
        if (state_reg == B_LOAD && pop) begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[BLOCK_WORDS - 1] <= pop_data.word;
            if (load_cnt_reg == 4'(BLOCK_WORDS - 1)) begin
                v_reg <= hash_reg;
            end
        end else if (state_reg == B_ROUND) begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[BLOCK_WORDS - 1] <= w_new;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

`ifndef SYNTHESIS
    // rounds start only after a full block was loaded
    a_full_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_ROUND && $past(state_reg) == B_LOAD) |-> load_cnt_reg == '0)
        else $error("rounds started on a partial block");

    // the update follows exactly the sixty-fourth round
    a_rounds_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_UPD) |-> $past(round_cnt_reg) == 6'(ROUNDS - 1))
        else $error("hash update before all rounds ran");

    // after the last digest word the initial hash is restored
    a_hash_restored: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_take && m_last_word) |=> (state_reg == B_LOAD && hash_reg[0] == INIT_HASH[0]
                                       && hash_reg[7] == INIT_HASH[7]))
        else $error("initial hash not restored after digest");

    // no block word is taken while a digest is pending
    a_no_load_during_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !pop_ready)
        else $error("block word taken during digest output");
`endif

endmodule

### rtl/core/sha256_hash_engine.sv
// SHA-256 engine: one round per cycle; each block is loaded, run through 64 rounds and added into the hash.
// The compression core takes no new block words while it runs its rounds; the queue holds them meanwhile.
// After the last word, the remaining padding blocks are compressed, then the digest comes out as 8 words.
// The front end pads while the core compresses, through a QUEUE_DEPTH word queue.
// Reset (aresetn low, synchronous) clears all control state and loads the initial hash.
module sha256_hash_engine #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] message_word, [34:32] valid_bytes, zero fill
    input  logic        s_tlast,   // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, zero fill
    output logic        m_tlast    // last_word
);
    import sha256_pkg::*;

    logic        push_valid;
    logic        push_ready;
    blk_word_t   push_data;
    logic        pop_valid;
    logic        pop_ready;
    blk_word_t   pop_data;
    logic [31:0] digest_word;
    logic [2:0]  word_index;

    sha256_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_word        (s_tdata[31:0]),
        .s_valid_bytes (s_tdata[34:32]),
        .s_last        (s_tlast),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_data     (push_data)
    );

    sha256_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_data   (push_data),
        .out_valid (pop_valid),
        .out_ready (pop_ready),
        .out_data  (pop_data)
    );

    sha256_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_data      (pop_data),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_digest_word (digest_word),
        .m_word_index  (word_index),
        .m_last_word   (m_tlast)
    );

    assign m_tdata = {5'b00000, word_index, digest_word};

endmodule
